// ===== rtl/bvs_pkg.sv =====
// Shared types, sizes and codes for the bounded value set.
// Used by every module of the block and by its checker; depends on nothing.
`default_nettype none

package bvs_pkg;

   // Store geometry
   localparam int SET_DEPTH = 16;
   localparam int SLOT_W    = (SET_DEPTH > 1) ? $clog2(SET_DEPTH) : 1;
   localparam int CNT_W     = $clog2(SET_DEPTH + 1);

   // Fixed field widths
   localparam int VALUE_W     = 32;
   localparam int CAP_W       = 5;
   localparam int SLOT_OUT_W  = 4;
   localparam int COUNT_OUT_W = 5;
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;
   localparam int LIM_W       = (CNT_W > CAP_W) ? CNT_W : CAP_W;

   // Register map: index is byte address / 4
   localparam logic REG_CAPACITY = 1'b0;
   localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

   typedef enum logic {
      CMD_ADD    = 1'b0,
      CMD_REMOVE = 1'b1
   } command_type;

   typedef enum logic [2:0] {
      ST_ADDED     = 3'd0,
      ST_REMOVED   = 3'd1,
      ST_FULL      = 3'd2,
      ST_PRESENT   = 3'd3,
      ST_NOT_FOUND = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_MOVE_RD,
      S_MOVE_WR,
      S_DONE
   } state_type;

   typedef struct packed {
      logic               rd_en;
      logic [SLOT_W-1:0]  rd_addr;
      logic               wr_en;
      logic [SLOT_W-1:0]  wr_addr;
      logic [VALUE_W-1:0] wr_data;
   } mem_req_type;

   typedef struct packed {
      status_type             status;
      logic [SLOT_OUT_W-1:0]  slot;
      logic [COUNT_OUT_W-1:0] member_count;
   } result_type;

endpackage

`default_nettype wire

// ===== rtl/bvs_store.sv =====
// Member store: one write port, one registered read port.
// Depends on bvs_pkg for sizes and the access struct.
`default_nettype none

module bvs_store (
   input  wire logic                        clock,
   input  wire bvs_pkg::mem_req_type        mem_req,
   output logic [bvs_pkg::VALUE_W-1:0]      rd_data
);

   logic [bvs_pkg::VALUE_W-1:0] mem [bvs_pkg::SET_DEPTH];
   logic [bvs_pkg::VALUE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem[mem_req.wr_addr] <= mem_req.wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_req.rd_en) begin
         rd_data_ff <= mem[mem_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/bvs_ctrl.sv =====
// Sequencer: scans the store for a value, appends or swap-removes, keeps the count.
// Depends on bvs_pkg; drives bvs_store through a mem_req_type struct.
`default_nettype none

module bvs_ctrl (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           start,
   input  wire logic                           req_command,
   input  wire logic [bvs_pkg::VALUE_W-1:0]    req_value,
   input  wire logic [bvs_pkg::CAP_W-1:0]      cap_limit,
   input  wire logic                           out_free,
   input  wire logic [bvs_pkg::VALUE_W-1:0]    rd_data,
   output logic                                idle,
   output logic                                done,
   output bvs_pkg::mem_req_type                mem_req,
   output bvs_pkg::result_type                 result
);

   bvs_pkg::state_type            state_ff, state_in;
   bvs_pkg::command_type          cmd_ff, cmd_in;
   logic [bvs_pkg::VALUE_W-1:0]   value_ff, value_in;
   logic [bvs_pkg::CNT_W-1:0]     count_ff, count_in;
   logic [bvs_pkg::CNT_W-1:0]     rd_idx_ff, rd_idx_in;
   logic                          cmp_vld_ff, cmp_vld_in;
   logic [bvs_pkg::SLOT_W-1:0]    cmp_idx_ff, cmp_idx_in;
   logic [bvs_pkg::SLOT_W-1:0]    pos_ff, pos_in;
   bvs_pkg::result_type           res_ff, res_in;

   logic                          full;
   logic                          hit;
   logic                          scan_end;
   logic [bvs_pkg::CNT_W-1:0]     last_idx;

   // Refuse adds once count reaches the smaller of the limit and the store depth
   assign full = (count_ff >= bvs_pkg::CNT_W'(bvs_pkg::SET_DEPTH)) ||
                 (bvs_pkg::LIM_W'(count_ff) >= bvs_pkg::LIM_W'(cap_limit));
   assign hit      = cmp_vld_ff && (rd_data == value_ff);
   assign scan_end = !hit && (rd_idx_ff >= count_ff);
   assign last_idx = count_ff - bvs_pkg::CNT_W'(1);

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bvs_pkg::S_IDLE: begin
            if (start) begin
               if (bvs_pkg::command_type'(req_command) == bvs_pkg::CMD_ADD && full) begin
                  state_in = bvs_pkg::S_DONE;
               end else begin
                  state_in = bvs_pkg::S_SCAN;
               end
            end
         end
         bvs_pkg::S_SCAN: begin
            if (hit) begin
               state_in = (cmd_ff == bvs_pkg::CMD_REMOVE) ? bvs_pkg::S_MOVE_RD
                                                          : bvs_pkg::S_DONE;
            end else if (scan_end) begin
               state_in = bvs_pkg::S_DONE;
            end
         end
         bvs_pkg::S_MOVE_RD: state_in = bvs_pkg::S_MOVE_WR;
         bvs_pkg::S_MOVE_WR: state_in = bvs_pkg::S_DONE;
         bvs_pkg::S_DONE: begin
            if (out_free) begin
               state_in = bvs_pkg::S_IDLE;
            end
         end
         default: state_in = bvs_pkg::S_IDLE;
      endcase
   end

   // Outputs: store accesses and handshake strobes
   always_comb begin
      mem_req         = '0;
      mem_req.wr_data = value_ff;
      idle            = 1'b0;
      done            = 1'b0;
      case (state_ff)
         bvs_pkg::S_IDLE: idle = 1'b1;
         bvs_pkg::S_SCAN: begin
            if (!hit && !scan_end) begin
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = rd_idx_ff[bvs_pkg::SLOT_W-1:0];
            end else if (scan_end && cmd_ff == bvs_pkg::CMD_ADD) begin
               // append at the first free slot
               mem_req.wr_en   = 1'b1;
               mem_req.wr_addr = count_ff[bvs_pkg::SLOT_W-1:0];
            end
         end
         bvs_pkg::S_MOVE_RD: begin
            mem_req.rd_en   = 1'b1;
            mem_req.rd_addr = last_idx[bvs_pkg::SLOT_W-1:0];
         end
         bvs_pkg::S_MOVE_WR: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = pos_ff;
            mem_req.wr_data = rd_data;
         end
         bvs_pkg::S_DONE: done = out_free;
         default: ;
      endcase
   end

   // Datapath next values
   always_comb begin
      cmd_in     = cmd_ff;
      value_in   = value_ff;
      count_in   = count_ff;
      rd_idx_in  = rd_idx_ff;
      cmp_vld_in = 1'b0;
      cmp_idx_in = cmp_idx_ff;
      pos_in     = pos_ff;
      res_in     = res_ff;
      case (state_ff)
         bvs_pkg::S_IDLE: begin
            if (start) begin
               cmd_in    = bvs_pkg::command_type'(req_command);
               value_in  = req_value;
               rd_idx_in = '0;
               res_in.status       = bvs_pkg::ST_FULL;
               res_in.slot         = '0;
               res_in.member_count = bvs_pkg::COUNT_OUT_W'(count_ff);
            end
         end
         bvs_pkg::S_SCAN: begin
            if (hit) begin
               pos_in = cmp_idx_ff;
               res_in.status = bvs_pkg::ST_PRESENT;
            end else if (scan_end) begin
               if (cmd_ff == bvs_pkg::CMD_ADD) begin
                  count_in            = count_ff + bvs_pkg::CNT_W'(1);
                  res_in.status       = bvs_pkg::ST_ADDED;
                  res_in.slot         = bvs_pkg::SLOT_OUT_W'(count_ff);
                  res_in.member_count = bvs_pkg::COUNT_OUT_W'(count_in);
               end else begin
                  res_in.status = bvs_pkg::ST_NOT_FOUND;
               end
            end else begin
               // one read in flight per cycle, compared in the next cycle
               cmp_vld_in = 1'b1;
               cmp_idx_in = rd_idx_ff[bvs_pkg::SLOT_W-1:0];
               rd_idx_in  = rd_idx_ff + bvs_pkg::CNT_W'(1);
            end
         end
         bvs_pkg::S_MOVE_WR: begin
            count_in            = last_idx;
            res_in.status       = bvs_pkg::ST_REMOVED;
            res_in.slot         = bvs_pkg::SLOT_OUT_W'(pos_ff);
            res_in.member_count = bvs_pkg::COUNT_OUT_W'(last_idx);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= bvs_pkg::S_IDLE;
         count_ff   <= '0;
         cmp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         cmp_vld_ff <= cmp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff     <= cmd_in;
      value_ff   <= value_in;
      rd_idx_ff  <= rd_idx_in;
      cmp_idx_ff <= cmp_idx_in;
      pos_ff     <= pos_in;
      res_ff     <= res_in;
   end

   assign result = res_ff;

endmodule

`default_nettype wire

// ===== rtl/bounded_value_set.sv =====
// Top level of the bounded value set: register port, request handshake, response register.
// Depends on bvs_pkg, bvs_store and bvs_ctrl.
//
//   port group | direction | handshake          | contents
//   req_*      | in        | valid / stall      | command, value
//   rsp_*      | out       | valid / stall      | status, slot, member_count
//   csr_*      | in / out  | APB setup + access | capacity_limit at byte address 0
//
// An add refused as full skips the scan; any other request scans the members until a hit
// or past the last one: the scan issues one store read per cycle and compares each word
// on the following cycle, and a remove with a hit then adds a read and a write.
// Reset is synchronous and empties the set; the store itself needs no clearing pass
// since only slots below the member count are ever read.
// A finished response waits in the output register while the next request runs;
// that request only stalls at its end if the previous response is still held.
`default_nettype none

module bounded_value_set (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic                                req_command,
   input  wire logic [bvs_pkg::VALUE_W-1:0]         req_value,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic [2:0]                               rsp_status,
   output logic [bvs_pkg::SLOT_OUT_W-1:0]           rsp_slot,
   output logic [bvs_pkg::COUNT_OUT_W-1:0]          rsp_member_count,
   input  wire logic                                csr_psel,
   input  wire logic                                csr_penable,
   input  wire logic                                csr_pwrite,
   input  wire logic [bvs_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  wire logic [bvs_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [bvs_pkg::CSR_DATA_W-1:0]           csr_prdata,
   output logic                                     csr_pready
);

   logic [bvs_pkg::CAP_W-1:0]   cap_ff, cap_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   bvs_pkg::result_type         rsp_ff, rsp_in;

   logic                        ctrl_idle;
   logic                        ctrl_done;
   logic                        out_free;
   logic                        start;
   logic                        csr_wr;
   bvs_pkg::mem_req_type        mem_req;
   bvs_pkg::result_type         ctrl_result;
   logic [bvs_pkg::VALUE_W-1:0] rd_data;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = bvs_pkg::CSR_DATA_W'(cap_ff);

   always_comb begin
      cap_in = cap_ff;
      if (csr_wr && csr_paddr[2] == bvs_pkg::REG_CAPACITY) begin
         cap_in = csr_pwdata[bvs_pkg::CAP_W-1:0];
      end
   end

   assign req_stall = !ctrl_idle;
   assign start     = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (ctrl_done) begin
         rsp_valid_in = 1'b1;
         rsp_in       = ctrl_result;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff       <= bvs_pkg::CAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         cap_ff       <= cap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_ff.status;
   assign rsp_slot         = rsp_ff.slot;
   assign rsp_member_count = rsp_ff.member_count;

   bvs_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .req_command (req_command),
      .req_value   (req_value),
      .cap_limit   (cap_ff),
      .out_free    (out_free),
      .rd_data     (rd_data),
      .idle        (ctrl_idle),
      .done        (ctrl_done),
      .mem_req     (mem_req),
      .result      (ctrl_result)
   );

   bvs_store u_store (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

endmodule

`default_nettype wire

// ===== rtl/bvs_checker.sv =====
// Port-level checks for bounded_value_set, attached by the bind at the end.
// Depends on bvs_pkg for widths and status codes.
`default_nettype none

module bvs_checker (
   input wire logic                                clock,
   input wire logic                                reset,
   input wire logic                                rsp_valid,
   input wire logic                                rsp_stall,
   input wire logic [2:0]                          rsp_status,
   input wire logic [bvs_pkg::SLOT_OUT_W-1:0]      rsp_slot,
   input wire logic [bvs_pkg::COUNT_OUT_W-1:0]     rsp_member_count
);

   // hold a stalled response
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status) &&
         $stable(rsp_slot) && $stable(rsp_member_count))
      else $error("stalled response changed");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // refused requests report slot zero
   a_refused_slot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == bvs_pkg::ST_FULL || rsp_status == bvs_pkg::ST_PRESENT ||
         rsp_status == bvs_pkg::ST_NOT_FOUND) |-> rsp_slot == '0)
      else $error("refused request names a slot");

   // an append lands just below the new count
   a_added_slot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == bvs_pkg::ST_ADDED |->
         rsp_member_count == bvs_pkg::COUNT_OUT_W'(rsp_slot) + bvs_pkg::COUNT_OUT_W'(1))
      else $error("added slot does not match count");

   // a refilled slot never lies beyond the new count
   a_removed_slot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == bvs_pkg::ST_REMOVED |->
         bvs_pkg::COUNT_OUT_W'(rsp_slot) <= rsp_member_count)
      else $error("removed slot beyond count");

endmodule

bind bounded_value_set bvs_checker u_bvs_checker (.*);

`default_nettype wire

// ===== verif/bounded_value_set_tb.sv =====
// Self-checking bench for bounded_value_set: a directed table, then random add and remove
// phases under several capacity limits, each response checked against table or model.
// Depends on bvs_pkg and the bounded_value_set RTL only.

module bounded_value_set_tb;

   localparam int CYCLE_LIMIT     = 400000;
   localparam int SETTLE_CYCLES   = 24;
   localparam int DRAIN_CYCLES    = 40;
   localparam int PHASES          = 8;
   localparam int ITEMS_PER_PHASE = 220;
   localparam int POOL_SIZE       = 16;
   localparam logic [bvs_pkg::CSR_ADDR_W-1:0] CAP_ADDR =
      bvs_pkg::CSR_ADDR_W'(4 * bvs_pkg::REG_CAPACITY);

   typedef enum logic {
      ROW_REQUEST   = 1'b0,
      ROW_CAP_WRITE = 1'b1
   } row_kind_type;

   typedef struct packed {
      row_kind_type         kind;
      bvs_pkg::command_type cmd;
      logic [31:0]          operand;
      logic                 known;
      bvs_pkg::result_type  outcome;
   } step_row_type;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_stall;
   logic                            req_command = 1'b0;
   logic [bvs_pkg::VALUE_W-1:0]     req_value = '0;
   logic                            rsp_valid;
   logic                            rsp_stall = 1'b0;
   logic [2:0]                      rsp_status;
   logic [bvs_pkg::SLOT_OUT_W-1:0]  rsp_slot;
   logic [bvs_pkg::COUNT_OUT_W-1:0] rsp_member_count;
   logic                            csr_psel = 1'b0;
   logic                            csr_penable = 1'b0;
   logic                            csr_pwrite = 1'b0;
   logic [bvs_pkg::CSR_ADDR_W-1:0]  csr_paddr = '0;
   logic [bvs_pkg::CSR_DATA_W-1:0]  csr_pwdata = '0;
   logic [bvs_pkg::CSR_DATA_W-1:0]  csr_prdata;
   logic                            csr_pready;

   bounded_value_set u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_command(req_command), .req_value(req_value),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_status(rsp_status), .rsp_slot(rsp_slot), .rsp_member_count(rsp_member_count),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata), .csr_pready(csr_pready)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Model of the set: members packed from slot 0, plus the count and the limit
   logic [bvs_pkg::VALUE_W-1:0] set_model [bvs_pkg::SET_DEPTH];
   int unsigned                 member_count_model = 0;
   int unsigned                 cap_model = 16;
   logic [bvs_pkg::VALUE_W-1:0] value_pool [POOL_SIZE];

   bvs_pkg::result_type pending_results[$];
   int mismatch_count = 0;
   int requests_sent = 0;
   int responses_checked = 0;
   int cap_writes = 0;
   int peak_members = 0;
   int status_seen [5] = '{0, 0, 0, 0, 0};
   int cycle_count = 0;
   int burst_left = 1;
   bit gaps_on = 1'b1;

   step_row_type directed_steps [0:21] = '{
      '{ROW_REQUEST, bvs_pkg::CMD_ADD, 32'h0000_0000, 1'b1, '{bvs_pkg::ST_ADDED, 4'd0, 5'd1}},
      '{ROW_REQUEST, bvs_pkg::CMD_ADD, 32'h0000_0000, 1'b1, '{bvs_pkg::ST_PRESENT, 4'd0, 5'd1}},
      '{ROW_REQUEST, bvs_pkg::CMD_ADD, 32'hFFFF_FFFF, 1'b1, '{bvs_pkg::ST_ADDED, 4'd1, 5'd2}},
      '{ROW_REQUEST, bvs_pkg::CMD_REMOVE, 32'h0000_0000, 1'b1,
        '{bvs_pkg::ST_REMOVED, 4'd0, 5'd1}},
      '{ROW_REQUEST, bvs_pkg::CMD_REMOVE, 32'h0000_0000, 1'b1,
        '{bvs_pkg::ST_NOT_FOUND, 4'd0, 5'd1}},
      // last member: slot refilled with itself, then cleared in the model
      '{ROW_REQUEST, bvs_pkg::CMD_REMOVE, 32'hFFFF_FFFF, 1'b1,
        '{bvs_pkg::ST_REMOVED, 4'd0, 5'd0}},
      // the model's cleared slots hold zero but must not match
      '{ROW_REQUEST, bvs_pkg::CMD_REMOVE, 32'h0000_0000, 1'b1,
        '{bvs_pkg::ST_NOT_FOUND, 4'd0, 5'd0}},
      '{ROW_CAP_WRITE, bvs_pkg::CMD_ADD, 32'd0, 1'b0, '{bvs_pkg::ST_ADDED, 4'd0, 5'd0}},
      '{ROW_REQUEST, bvs_pkg::CMD_ADD, 32'h0000_0005, 1'b1, '{bvs_pkg::ST_FULL, 4'd0, 5'd0}},
      '{ROW_CAP_WRITE, bvs_pkg::CMD_ADD, 32'd2, 1'b0, '{bvs_pkg::ST_ADDED, 4'd0, 5'd0}},
      '{ROW_REQUEST, bvs_pkg::CMD_ADD, 32'h0000_0001, 1'b1, '{bvs_pkg::ST_ADDED, 4'd0, 5'd1}},
      '{ROW_REQUEST, bvs_pkg::CMD_ADD, 32'h8000_0000, 1'b1, '{bvs_pkg::ST_ADDED, 4'd1, 5'd2}},
      // fullness is tested before the duplicate search
      '{ROW_REQUEST, bvs_pkg::CMD_ADD, 32'h0000_0001, 1'b1, '{bvs_pkg::ST_FULL, 4'd0, 5'd2}},
      '{ROW_CAP_WRITE, bvs_pkg::CMD_ADD, 32'd1, 1'b0, '{bvs_pkg::ST_ADDED, 4'd0, 5'd0}},
      '{ROW_REQUEST, bvs_pkg::CMD_ADD, 32'h0000_0003, 1'b1, '{bvs_pkg::ST_FULL, 4'd0, 5'd2}},
      '{ROW_REQUEST, bvs_pkg::CMD_REMOVE, 32'h0000_0001, 1'b0,
        '{bvs_pkg::ST_ADDED, 4'd0, 5'd0}},
      '{ROW_REQUEST, bvs_pkg::CMD_REMOVE, 32'h8000_0000, 1'b1,
        '{bvs_pkg::ST_REMOVED, 4'd0, 5'd0}},
      '{ROW_CAP_WRITE, bvs_pkg::CMD_ADD, 32'd31, 1'b0, '{bvs_pkg::ST_ADDED, 4'd0, 5'd0}},
      '{ROW_REQUEST, bvs_pkg::CMD_ADD, 32'hA5A5_5A5A, 1'b0, '{bvs_pkg::ST_ADDED, 4'd0, 5'd0}},
      '{ROW_REQUEST, bvs_pkg::CMD_REMOVE, 32'h5A5A_A5A5, 1'b0,
        '{bvs_pkg::ST_ADDED, 4'd0, 5'd0}},
      '{ROW_REQUEST, bvs_pkg::CMD_ADD, 32'h7FFF_FFFF, 1'b0, '{bvs_pkg::ST_ADDED, 4'd0, 5'd0}},
      '{ROW_REQUEST, bvs_pkg::CMD_REMOVE, 32'hA5A5_5A5A, 1'b0,
        '{bvs_pkg::ST_ADDED, 4'd0, 5'd0}}
   };

   int phase_caps [PHASES] = '{16, 31, 0, 1, 5, 15, 17, -1};
   int add_pct    [PHASES] = '{80, 70, 50, 40, 60, 65, 75, 55};

   function automatic bvs_pkg::result_type apply_set_update(
         bvs_pkg::command_type cmd, logic [bvs_pkg::VALUE_W-1:0] v);
      bvs_pkg::result_type r;
      int                  hit_slot;
      int unsigned         limit;
      r.status       = bvs_pkg::ST_NOT_FOUND;
      r.slot         = '0;
      r.member_count = '0;
      hit_slot = -1;
      limit = (cap_model < bvs_pkg::SET_DEPTH) ? cap_model : bvs_pkg::SET_DEPTH;
      for (int i = 0; i < member_count_model; i++) begin
         if (hit_slot < 0 && set_model[i] == v) hit_slot = i;
      end
      if (cmd == bvs_pkg::CMD_ADD) begin
         if (member_count_model >= limit) begin
            r.status = bvs_pkg::ST_FULL;
         end else if (hit_slot >= 0) begin
            r.status = bvs_pkg::ST_PRESENT;
         end else begin
            set_model[member_count_model] = v;
            r.slot = bvs_pkg::SLOT_OUT_W'(member_count_model);
            member_count_model++;
            r.status = bvs_pkg::ST_ADDED;
         end
      end else if (hit_slot >= 0) begin
         // swap the last member into the hole and clear the old last slot
         set_model[hit_slot] = set_model[member_count_model - 1];
         set_model[member_count_model - 1] = '0;
         member_count_model--;
         r.slot = bvs_pkg::SLOT_OUT_W'(hit_slot);
         r.status = bvs_pkg::ST_REMOVED;
      end
      r.member_count = bvs_pkg::COUNT_OUT_W'(member_count_model);
      if (member_count_model > peak_members) peak_members = member_count_model;
      return r;
   endfunction

   function automatic logic [bvs_pkg::VALUE_W-1:0] pick_value(bvs_pkg::command_type cmd);
      int roll;
      roll = $urandom_range(0, 99);
      if (member_count_model > 0 && roll < ((cmd == bvs_pkg::CMD_REMOVE) ? 55 : 10))
         return set_model[$urandom_range(0, member_count_model - 1)];
      if (roll < 80) return value_pool[$urandom_range(0, POOL_SIZE - 1)];
      return $urandom();
   endfunction

   task automatic send_request(input bvs_pkg::command_type cmd,
                               input logic [bvs_pkg::VALUE_W-1:0] v,
                               input logic known, input bvs_pkg::result_type typed);
      bvs_pkg::result_type predicted;
      req_valid   <= 1'b1;
      req_command <= cmd;
      req_value   <= v;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predicted = apply_set_update(cmd, v);
      pending_results.push_back(known ? typed : predicted);
      requests_sent++;
      burst_left--;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         if (gaps_on) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clock);
         end
      end
   endtask

   task automatic settle_block();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write only with the set idle: drain every response first
   task automatic write_capacity(input logic [bvs_pkg::CSR_DATA_W-1:0] data);
      settle_block();
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= CAP_ADDR;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      cap_model = data[bvs_pkg::CAP_W-1:0];
      cap_writes++;
   endtask

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("%0t: no progress within %0d cycles, %0d responses outstanding",
                  $time, CYCLE_LIMIT, pending_results.size());
         $display("simulation failed");
         $finish;
      end
   end

   always @(posedge clock) begin : check_response
      bvs_pkg::result_type want;
      int                  stall_mode;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected response: status %0d slot %0d count %0d",
                     $time, rsp_status, rsp_slot, rsp_member_count);
            mismatch_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_status !== want.status) begin
               $display("%0t: status expected %0d actual %0d", $time, want.status, rsp_status);
               mismatch_count++;
            end
            if (rsp_slot !== want.slot) begin
               $display("%0t: slot expected %0d actual %0d", $time, want.slot, rsp_slot);
               mismatch_count++;
            end
            if (rsp_member_count !== want.member_count) begin
               $display("%0t: member_count expected %0d actual %0d",
                        $time, want.member_count, rsp_member_count);
               mismatch_count++;
            end
            responses_checked++;
            status_seen[want.status]++;
         end
      end
      // cycle through never-stall, light, heavy and long-run stall patterns
      stall_mode = (cycle_count / 256) % 4;
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 3) == 0);
         2: rsp_stall <= ($urandom_range(0, 3) != 0);
         default: begin
            if ($urandom_range(0, 31) < 4) rsp_stall <= ~rsp_stall;
         end
      endcase
   end

   initial begin
      bvs_pkg::command_type           cmd;
      int                             cap;
      logic [bvs_pkg::CSR_DATA_W-1:0] cap_word;
      foreach (set_model[i]) set_model[i] = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_steps[k]) begin
         if (directed_steps[k].kind == ROW_CAP_WRITE)
            write_capacity(directed_steps[k].operand);
         else
            send_request(directed_steps[k].cmd, directed_steps[k].operand,
                         directed_steps[k].known, directed_steps[k].outcome);
      end

      for (int p = 0; p < PHASES; p++) begin
         cap = (phase_caps[p] < 0) ? $urandom_range(0, 31) : phase_caps[p];
         cap_word = bvs_pkg::CSR_DATA_W'(cap);
         // upper bits of the write data are ignored
         if ($urandom_range(0, 1)) cap_word = ($urandom() & ~32'h1F) | cap_word;
         write_capacity(cap_word);
         foreach (value_pool[i]) value_pool[i] = $urandom();
         value_pool[0] = 32'h0000_0000;
         value_pool[1] = 32'hFFFF_FFFF;
         value_pool[2] = 32'h8000_0001;
         gaps_on = (p % 3) != 1;
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            cmd = ($urandom_range(0, 99) < add_pct[p]) ? bvs_pkg::CMD_ADD
                                                       : bvs_pkg::CMD_REMOVE;
            send_request(cmd, pick_value(cmd), 1'b0, '0);
         end
      end

      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d requests, %0d responses checked, %0d limit writes, peak of %0d members",
               requests_sent, responses_checked, cap_writes, peak_members);
      $display("added %0d, removed %0d, full %0d, present %0d, not found %0d",
               status_seen[bvs_pkg::ST_ADDED], status_seen[bvs_pkg::ST_REMOVED],
               status_seen[bvs_pkg::ST_FULL], status_seen[bvs_pkg::ST_PRESENT],
               status_seen[bvs_pkg::ST_NOT_FOUND]);
      if (mismatch_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
